@@ sv/lstcd_pkg.sv @@
package lstcd_pkg;

  // Field widths of one input byte and one reading
  localparam int unsigned CharW  = 8;
  localparam int unsigned StepW  = 10;
  localparam int unsigned IndexW = 10;
  localparam int unsigned AngleW = 11;
  localparam int unsigned DistW  = 13;
  localparam int unsigned CodeW  = 5;
  localparam int unsigned SixW   = 6;
  localparam int unsigned ValueW = 2 * SixW;

  // Configuration port widths and register indexes
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 10;

  localparam logic [CfgAddrW-1:0] REG_FROM_STEP  = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_VALID_FROM = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_VALID_TO   = 2'd2;

  // Register reset values
  localparam logic [StepW-1:0] FromStepReset  = 10'd0;
  localparam logic [StepW-1:0] ValidFromReset = 10'd44;
  localparam logic [StepW-1:0] ValidToReset   = 10'd725;

  // Step of the beam at 0 degrees (step 0 lies at -135 degrees), in units of pi/512
  localparam logic [AngleW-1:0] AngleOffset = 11'd384;

  // Characters and thresholds of the protocol
  localparam logic [CharW-1:0]  CharZero   = 8'h30;
  localparam logic [CharW-1:0]  CharTab    = 8'h09;
  localparam logic [CharW-1:0]  CharCr     = 8'h0D;
  localparam logic [CharW-1:0]  CharSpace  = 8'h20;
  localparam logic [ValueW-1:0] ErrorLimit = 12'd20;

  localparam logic [StepW-1:0]  StepMax  = '1;
  localparam logic [IndexW-1:0] IndexMax = '1;

  // Result kinds
  localparam logic KIND_READING  = 1'b0;
  localparam logic KIND_REJECTED = 1'b1;

  // Decoder phase within a response
  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

endpackage

@@ sv/lstcd_in_if.sv @@
interface lstcd_in_if
  import lstcd_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_in;
  logic             start_req;

  modport source (output valid, output char_in, output start_req, input ready);
  modport sink (input valid, input char_in, input start_req, output ready);
endinterface

@@ sv/lstcd_out_if.sv @@
interface lstcd_out_if
  import lstcd_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [IndexW-1:0]        reading_index;
  logic signed [AngleW-1:0] angle_units;
  logic signed [DistW-1:0]  distance;
  logic [CodeW-1:0]         error_code;
  logic                     error_flag;

  modport source (output valid, output kind, output reading_index, output angle_units,
                  output distance, output error_code, output error_flag, input ready);
  modport sink (input valid, input kind, input reading_index, input angle_units,
                input distance, input error_code, input error_flag, output ready);
endinterface

@@ sv/lstcd_cfg_if.sv @@
interface lstcd_cfg_if
  import lstcd_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [CfgAddrW-1:0] index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/laser_scan_two_char_decoder_core.sv @@
// Channel   Direction  Word
// in_ch     sink       char_in (8), start_req (1)
// out_ch    source     kind, reading_index, angle_units, distance, error_code, error_flag
// cfg       sink       index (2), data (10): from_step, valid_from, valid_to
//
// One byte is taken every cycle while the output is not stalled; a byte passes through the
// input register and its reading, if any, is then registered in the output register.
// The decode is a few compares, an 8-bit character subtract and an 11-bit angle subtract
// between the two registers.
// Reset (synchronous) empties both registers, clears the phase to waiting and restores
// the register defaults. A stalled output holds both stages; cfg is always ready.
module laser_scan_two_char_decoder_core
  import lstcd_pkg::*;
  (
  input  logic        clk,
  input  logic        rst,
  lstcd_in_if.sink    in_ch,
  lstcd_out_if.source out_ch,
  lstcd_cfg_if.sink   cfg
);

  // Configuration registers
  logic [StepW-1:0] from_step;
  logic [StepW-1:0] valid_from;
  logic [StepW-1:0] valid_to;

  // Input register
  logic             in_valid;
  logic [CharW-1:0] in_char;
  logic             in_start;

  // Decoder state
  phase_t            phase, phase_next;
  logic [SixW-1:0]   held_high_bits, held_high_bits_next;
  logic [StepW-1:0]  step_counter, step_counter_next;
  logic [IndexW-1:0] index_counter, index_counter_next;

  // Result register
  logic                     res_valid;
  logic                     res_kind;
  logic [IndexW-1:0]        res_index;
  logic signed [AngleW-1:0] res_angle;
  logic signed [DistW-1:0]  res_dist;
  logic [CodeW-1:0]         res_code;
  logic                     res_flag;

  // Decode results of the byte in the input register
  logic                     emit;
  logic                     emit_kind;
  logic [IndexW-1:0]        emit_index;
  logic signed [AngleW-1:0] emit_angle;
  logic signed [DistW-1:0]  emit_dist;
  logic [CodeW-1:0]         emit_code;
  logic                     emit_flag;

  logic             advance;
  logic             is_space;
  logic [CharW-1:0] char_diff;
  logic [SixW-1:0]  six;
  logic [ValueW-1:0] value;
  logic             value_err;
  logic             in_window;

  // The pipeline moves whenever the result register is empty or being taken.
  assign advance     = !res_valid || out_ch.ready;
  assign in_ch.ready = !in_valid || advance;
  assign cfg.ready   = 1'b1;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      from_step  <= FromStepReset;
      valid_from <= ValidFromReset;
      valid_to   <= ValidToReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FROM_STEP:  from_step  <= cfg.data[StepW-1:0];
        REG_VALID_FROM: valid_from <= cfg.data[StepW-1:0];
        REG_VALID_TO:   valid_to   <= cfg.data[StepW-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_char  <= in_ch.char_in;
      in_start <= in_ch.start_req;
    end
  end

  // Character classification and the pair value.
  assign is_space  = ((in_char >= CharTab) && (in_char <= CharCr)) || (in_char == CharSpace);
  assign char_diff = in_char - CharZero;
  assign six       = char_diff[SixW-1:0];
  assign value     = {held_high_bits, six};
  assign value_err = value < ErrorLimit;
  assign in_window = (step_counter >= valid_from) && (step_counter <= valid_to);

  // Next state and the result for the byte in the input register.
  always_comb begin
    phase_next          = phase;
    held_high_bits_next = held_high_bits;
    step_counter_next   = step_counter;
    index_counter_next  = index_counter;
    emit       = 1'b0;
    emit_kind  = KIND_READING;
    emit_index = '0;
    emit_angle = '0;
    emit_dist  = '0;
    emit_code  = '0;
    emit_flag  = 1'b0;
    if (in_start) begin
      // A status byte restarts the response whatever came before.
      held_high_bits_next = '0;
      index_counter_next  = '0;
      step_counter_next   = from_step;
      if (in_char == CharZero) begin
        phase_next = PH_HIGH;
      end else begin
        phase_next = PH_WAIT;
        emit       = 1'b1;
        emit_kind  = KIND_REJECTED;
      end
    end else if (!is_space) begin
      unique case (phase)
        PH_HIGH: begin
          held_high_bits_next = six;
          phase_next          = PH_LOW;
        end
        PH_LOW: begin
          phase_next = PH_HIGH;
          if (step_counter != StepMax) begin
            step_counter_next = step_counter + 1'b1;
          end
          if (in_window) begin
            emit       = 1'b1;
            emit_index = index_counter;
            emit_angle = {1'b0, step_counter} - AngleOffset;
            emit_dist  = value_err ? '1 : {1'b0, value};
            emit_code  = value_err ? value[CodeW-1:0] : '0;
            emit_flag  = value_err;
            if (index_counter != IndexMax) begin
              index_counter_next = index_counter + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Decoder state advances when the byte leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_WAIT;
      held_high_bits <= '0;
      step_counter   <= '0;
      index_counter  <= '0;
    end else if (in_valid && advance) begin
      phase          <= phase_next;
      held_high_bits <= held_high_bits_next;
      step_counter   <= step_counter_next;
      index_counter  <= index_counter_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= in_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid && emit) begin
      res_kind  <= emit_kind;
      res_index <= emit_index;
      res_angle <= emit_angle;
      res_dist  <= emit_dist;
      res_code  <= emit_code;
      res_flag  <= emit_flag;
    end
  end

  assign out_ch.valid         = res_valid;
  assign out_ch.kind          = res_kind;
  assign out_ch.reading_index = res_index;
  assign out_ch.angle_units   = res_angle;
  assign out_ch.distance      = res_dist;
  assign out_ch.error_code    = res_code;
  assign out_ch.error_flag    = res_flag;

endmodule
